/* rtl/etmp_pkg.sv */
`default_nettype none

package etmp_pkg;

  localparam int unsigned NumPins = 32;
  localparam int unsigned IdxW    = $clog2(NumPins);
  localparam int unsigned CntW    = IdxW + 1;

  localparam logic [15:0] TimerMax  = 16'hFFFF;
  localparam logic [15:0] TimerZero = 16'h0000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_COMMIT = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  entry_index;
    logic [4:0]  entry_pin;
    logic [15:0] entry_reload;
    logic [5:0]  commit_count;
  } in_t;

  typedef struct packed {
    logic [31:0] pin_levels;
    logic        is_running;
    logic        step_fired;
    logic [4:0]  step_index;
    logic        rejected;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic fill;
    logic step;
    logic copy;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_fire;
    logic commit_start;
    logic fill_needed;
    logic fill_last;
    logic wrap_copy;
    logic copy_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/etmp_dp.sv */
`default_nettype none

module etmp_dp import etmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output out_t      out_data_o
);

  in_t              item_q;
  out_t             out_q;

  logic [4:0]       active_pin_q    [NumPins];
  logic [15:0]      active_reload_q [NumPins];
  logic [4:0]       shadow_pin_q    [NumPins];
  logic [15:0]      shadow_reload_q [NumPins];

  logic [CntW-1:0]  active_count_q, active_count_d;
  logic [CntW-1:0]  shadow_count_q, shadow_count_d;
  logic [IdxW-1:0]  index_q, index_d;
  logic             running_q, running_d;
  logic             pending_q, pending_d;
  logic [15:0]      timer_q, timer_d;
  logic [31:0]      level_q, level_d;
  logic [CntW-1:0]  sweep_q, sweep_d;
  logic             fired_q, fired_d;
  logic             rej_q, rej_d;

  logic [IdxW-1:0]  sweep_idx;
  logic [IdxW-1:0]  rd_addr;
  logic [4:0]       rd_pin;
  logic [15:0]      rd_reload;
  logic [31:0]      pin_bit;
  logic [CntW-1:0]  idx_inc;
  logic [CntW-1:0]  sweep_inc;
  logic             count_ok;
  logic             wrap;

  assign sweep_idx = sweep_q[IdxW-1:0];
  assign sweep_inc = sweep_q + CntW'(1);
  assign rd_addr   = cmd_i.fill ? sweep_idx : index_q;
  assign rd_pin    = active_pin_q[rd_addr];
  assign rd_reload = active_reload_q[index_q];
  assign pin_bit   = 32'(1) << rd_pin;
  assign idx_inc   = {1'b0, index_q} + CntW'(1);
  assign wrap      = idx_inc >= active_count_q;
  assign count_ok  = (item_q.commit_count != '0) &&
                     (item_q.commit_count <= CntW'(NumPins));

  always_comb begin
    sts_o.tick_fire    = (item_q.op == OP_TICK) && running_q && (timer_q == TimerMax);
    sts_o.commit_start = (item_q.op == OP_COMMIT) && count_ok && !running_q;
    sts_o.fill_needed  = (index_q == '0) && (active_count_q > CntW'(1));
    sts_o.fill_last    = sweep_inc == active_count_q;
    sts_o.wrap_copy    = wrap && !pending_q && (shadow_count_q != '0);
    sts_o.copy_last    = sweep_inc >= shadow_count_q;
  end

  always_comb begin
    active_count_d = active_count_q;
    shadow_count_d = shadow_count_q;
    index_d        = index_q;
    running_d      = running_q;
    pending_d      = pending_q;
    timer_d        = timer_q;
    level_d        = level_q;
    sweep_d        = sweep_q;
    fired_d        = fired_q;
    rej_d          = rej_q;

    if (cmd_i.exec) begin
      fired_d = 1'b0;
      rej_d   = 1'b0;
      sweep_d = CntW'(1);
      case (item_q.op)
        OP_TICK: begin
          if (running_q) begin
            fired_d = timer_q == TimerMax;
            timer_d = (timer_q == TimerMax) ? TimerZero : timer_q + 16'd1;
          end
        end
        OP_WRITE: begin
          pending_d = 1'b1;
        end
        OP_COMMIT: begin
          if (item_q.commit_count > CntW'(NumPins)) begin
            rej_d = 1'b1;
          end else if (item_q.commit_count == '0) begin
            timer_d        = TimerZero;
            running_d      = 1'b0;
            shadow_count_d = '0;
          end else begin
            shadow_count_d = item_q.commit_count;
            pending_d      = 1'b0;
            if (!running_q) begin
              // start: the sweep copies the shadow table next
              active_count_d = item_q.commit_count;
              index_d        = '0;
              running_d      = 1'b1;
              timer_d        = TimerMax;
              sweep_d        = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.fill) begin
      level_d = level_q | pin_bit;
      sweep_d = sweep_inc;
    end

    if (cmd_i.step) begin
      if (index_q != '0) begin
        level_d = level_q & ~pin_bit;
      end
      timer_d = rd_reload;
      sweep_d = '0;
      if (wrap) begin
        index_d = '0;
        if (!pending_q) begin
          active_count_d = shadow_count_q;
        end
      end else begin
        index_d = idx_inc[IdxW-1:0];
      end
    end

    if (cmd_i.copy) begin
      sweep_d = sweep_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      shadow_count_q <= '0;
      index_q        <= '0;
      running_q      <= 1'b0;
      pending_q      <= 1'b0;
      timer_q        <= TimerZero;
      level_q        <= '0;
      sweep_q        <= '0;
      fired_q        <= 1'b0;
      rej_q          <= 1'b0;
    end else begin
      active_count_q <= active_count_d;
      shadow_count_q <= shadow_count_d;
      index_q        <= index_d;
      running_q      <= running_d;
      pending_q      <= pending_d;
      timer_q        <= timer_d;
      level_q        <= level_d;
      sweep_q        <= sweep_d;
      fired_q        <= fired_d;
      rej_q          <= rej_d;
    end
  end

  // shadow table resets to zeros: a commit may copy slots never written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPins; i++) begin
        shadow_pin_q[i]    <= '0;
        shadow_reload_q[i] <= '0;
      end
    end else if (cmd_i.exec && (item_q.op == OP_WRITE)) begin
      shadow_pin_q[item_q.entry_index]    <= item_q.entry_pin;
      shadow_reload_q[item_q.entry_index] <= item_q.entry_reload;
    end
  end

  // active slots are read only below the count, and each of those is copied first
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy) begin
      active_pin_q[sweep_idx]    <= shadow_pin_q[sweep_idx];
      active_reload_q[sweep_idx] <= shadow_reload_q[sweep_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.out_load) begin
      out_q.pin_levels <= level_q;
      out_q.is_running <= running_q;
      out_q.step_fired <= fired_q;
      out_q.step_index <= index_q;
      out_q.rejected   <= rej_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* rtl/etmp_ctrl.sv */
`default_nettype none

module etmp_ctrl import etmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_FILL = 6'b000100,
    ST_STEP = 6'b001000,
    ST_COPY = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e st_q, st_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    st_d           = st_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    case (st_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.tick_fire) begin
          st_d = sts_i.fill_needed ? ST_FILL : ST_STEP;
        end else if (sts_i.commit_start) begin
          st_d = ST_COPY;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          st_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        st_d       = sts_i.wrap_copy ? ST_COPY : ST_DONE;
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        cmd_o.out_load = out_free;
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/edge_table_multi_pwm_core.sv */
// Channel  Dir  Handshake                  Word
// input    in   in_valid_i / in_stall_o    in_t  (op, entry fields, commit count)
// output   out  out_valid_o / out_stall_i  out_t (pin levels and status)
//
// Plain word (write, stop, reject, tick without a step, no-op): accept, EXEC,
// DONE. Step tick: accept, EXEC, a FILL set-high sweep at index 0 (more than
// one active entry), STEP, a shadow-table COPY at a wrap with no writes
// pending, DONE. Starting commit: accept, EXEC, table COPY, DONE. One word
// in flight; the output register holds a stalled result while the next word
// is accepted. Reset clears the shadow table, counters, flags and pins.
`default_nettype none

module edge_table_multi_pwm_core import etmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  cmd_t cmd;
  sts_t sts;

  etmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etmp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/etmp_checker.sv */
`default_nettype none

module etmp_checker import etmp_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // one word in flight: stall right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

  a_fired_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.step_fired |-> out_data_o.is_running)
    else $error("step fired while stopped");

  a_fired_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.step_fired && out_data_o.rejected))
    else $error("fired and rejected in one word");

endmodule

bind edge_table_multi_pwm_core etmp_checker u_etmp_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import etmp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomWords = 400;

  typedef struct {
    in_t         word;
    int unsigned gap;
    bit          drain;
  } issue_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_t  in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_t out_data_o;

  edge_table_multi_pwm_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // scheduler state mirrored by the predictor
  logic [4:0]  act_pin [NumPins];
  logic [15:0] act_rld [NumPins];
  logic [4:0]  sh_pin [NumPins];
  logic [15:0] sh_rld [NumPins];
  int unsigned act_cnt, sh_cnt, cur_idx;
  bit          running, writes_pending;
  logic [15:0] timer;
  logic [31:0] levels;

  issue_t issue_q[$];
  out_t   status_q[$];
  bit     burst_mode;
  bit     drain_next;
  int     idle_cycles;
  int     hold_left;
  int     sent_words, total_words, checked, errors, fires, rejects;
  int     cycles;

  function automatic void load_active();
    int unsigned n;
    n = (sh_cnt > NumPins) ? NumPins : sh_cnt;
    act_cnt = n;
    for (int i = 0; i < n; i++) begin
      act_pin[i] = sh_pin[i];
      act_rld[i] = sh_rld[i];
    end
  endfunction

  function automatic out_t schedule_edges(in_t w);
    out_t        r;
    bit          fired, rej;
    int unsigned slot;
    fired = 1'b0;
    rej = 1'b0;
    case (op_e'(w.op))
      OP_TICK: begin
        if (running) begin
          if (timer == TimerMax) begin
            timer = TimerZero;
            slot = (cur_idx < NumPins) ? cur_idx : 0;
            if (cur_idx == 0) begin
              for (int i = 1; i < act_cnt && i < NumPins; i++) levels[act_pin[i]] = 1'b1;
            end else begin
              levels[act_pin[slot]] = 1'b0;
            end
            timer = act_rld[slot];
            cur_idx++;
            if (cur_idx >= act_cnt) begin
              if (!writes_pending) load_active();
              cur_idx = 0;
            end
            fired = 1'b1;
          end else begin
            timer = timer + 16'd1;
          end
        end
      end
      OP_WRITE: begin
        if (w.entry_index < NumPins) begin
          sh_pin[w.entry_index] = w.entry_pin;
          sh_rld[w.entry_index] = w.entry_reload;
          writes_pending = 1'b1;
        end
      end
      OP_COMMIT: begin
        if (w.commit_count > NumPins) begin
          rej = 1'b1;
        end else if (w.commit_count == 0) begin
          timer = TimerZero;
          running = 1'b0;
          sh_cnt = 0;
        end else begin
          sh_cnt = w.commit_count;
          if (!running) begin
            load_active();
            cur_idx = 0;
            running = 1'b1;
            timer = TimerMax;
          end
          writes_pending = 1'b0;
        end
      end
      default: ;
    endcase
    r.pin_levels = levels;
    r.is_running = running;
    r.step_fired = fired;
    r.step_index = 5'(cur_idx);
    r.rejected   = rej;
    return r;
  endfunction

  task automatic check_status(out_t got);
    out_t want;
    if (status_q.size() == 0) begin
      $error("status word with nothing expected: %h", got);
      errors++;
      return;
    end
    want = status_q.pop_front();
    if (got.pin_levels !== want.pin_levels) begin
      $error("pin_levels expected %h actual %h", want.pin_levels, got.pin_levels);
      errors++;
    end
    if (got.is_running !== want.is_running) begin
      $error("is_running expected %b actual %b", want.is_running, got.is_running);
      errors++;
    end
    if (got.step_fired !== want.step_fired) begin
      $error("step_fired expected %b actual %b", want.step_fired, got.step_fired);
      errors++;
    end
    if (got.step_index !== want.step_index) begin
      $error("step_index expected %0d actual %0d", want.step_index, got.step_index);
      errors++;
    end
    if (got.rejected !== want.rejected) begin
      $error("rejected expected %b actual %b", want.rejected, got.rejected);
      errors++;
    end
  endtask

  // sender: offer queued words, idle between them, hold on a drain mark
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic offer;
    out_t want;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NumPins; i++) begin
        act_pin[i] = '0;
        act_rld[i] = '0;
        sh_pin[i] = '0;
        sh_rld[i] = '0;
      end
      act_cnt = 0;
      sh_cnt = 0;
      cur_idx = 0;
      running = 1'b0;
      writes_pending = 1'b0;
      timer = TimerZero;
      levels = '0;
      idle_cycles = 0;
    end else begin
      offer = in_valid && in_stall_o;
      if (in_valid && !in_stall_o) begin
        want = schedule_edges(in_data);
        status_q.push_back(want);
        fires += want.step_fired;
        rejects += want.rejected;
        sent_words++;
      end
      if (!offer && issue_q.size() != 0 && !(issue_q[0].drain && status_q.size() != 0)) begin
        if (idle_cycles < issue_q[0].gap) begin
          idle_cycles++;
        end else begin
          in_data <= issue_q[0].word;
          offer = 1'b1;
          idle_cycles = 0;
          void'(issue_q.pop_front());
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: check each word, then stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        check_status(out_data_o);
        checked++;
        if (checked % 180 == 120) hold_left = 400;
        else if ((checked / 64) % 3 == 1) hold_left = 0;
        else hold_left = $urandom_range(0, 13);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic add_word(in_t w);
    issue_t it;
    it.word = w;
    it.gap = burst_mode ? 0 : $urandom_range(0, 13);
    it.drain = drain_next;
    drain_next = 1'b0;
    issue_q.push_back(it);
  endtask

  function automatic in_t word_of(op_e op);
    in_t w;
    w.op = op;
    w.entry_index = 5'($urandom);
    w.entry_pin = 5'($urandom);
    w.entry_reload = 16'($urandom);
    w.commit_count = 6'($urandom);
    return w;
  endfunction

  function automatic in_t entry_word(logic [4:0] idx, logic [4:0] pin, logic [15:0] rld);
    in_t w;
    w = word_of(OP_WRITE);
    w.entry_index = idx;
    w.entry_pin = pin;
    w.entry_reload = rld;
    return w;
  endfunction

  function automatic in_t commit_word(logic [5:0] cnt);
    in_t w;
    w = word_of(OP_COMMIT);
    w.commit_count = cnt;
    return w;
  endfunction

  initial begin : run
    int k, n;
    logic [15:0] rld;
    // idle behavior, stop, rejects, no-op, table writes
    add_word(word_of(OP_TICK));
    add_word(commit_word(6'd0));
    add_word(commit_word(6'd33));
    add_word(commit_word(6'd63));
    add_word(word_of(OP_NOP));
    add_word(entry_word(5'd0, 5'd0, 16'hFFFF));
    add_word(entry_word(5'd1, 5'd31, 16'hFFFF));
    add_word(entry_word(5'd2, 5'd7, 16'hFFFE));
    add_word(entry_word(5'd31, 5'd16, 16'h0000));
    // start, run through a wrap with table copy
    add_word(commit_word(6'd3));
    repeat (4) add_word(word_of(OP_TICK));
    // pending write blocks the copy at wrap
    add_word(entry_word(5'd1, 5'd12, 16'hFFFF));
    repeat (3) add_word(word_of(OP_TICK));
    add_word(commit_word(6'd32));
    repeat (2) add_word(word_of(OP_TICK));
    add_word(commit_word(6'd0));
    add_word(word_of(OP_TICK));
    // full table started from idle, sweep the pins of entries 1 to 31 high
    add_word(commit_word(6'd32));
    add_word(word_of(OP_TICK));

    drain_next = 1'b1;
    while (issue_q.size() < 25 + RandomWords) begin
      if ($urandom_range(0, 3) == 0) burst_mode = !burst_mode;
      if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          k = ($urandom_range(0, 7) == 0) ? $urandom_range(7, NumPins) : $urandom_range(1, 6);
          if ($urandom_range(0, 1) == 0) add_word(commit_word(6'd0));
          for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0) rld = 16'($urandom);
            else rld = 16'hFFFF - 16'($urandom_range(0, 2));
            add_word(entry_word(5'(i), 5'($urandom), rld));
          end
          add_word(commit_word(6'(k)));
          n = $urandom_range(k, 3 * k + 6);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) add_word(word_of(op_e'($urandom_range(0, 3))));
            else add_word(word_of(OP_TICK));
          end
        end
        7: begin
          repeat ($urandom_range(1, 4)) add_word(word_of(op_e'($urandom_range(0, 3))));
        end
        8: begin
          add_word(commit_word(6'd0));
          repeat ($urandom_range(1, 3)) add_word(word_of(OP_TICK));
        end
        default: add_word(commit_word(6'($urandom_range(33, 63))));
      endcase
    end
    total_words = issue_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (sent_words < total_words || status_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("tb: %0d words sent, %0d status words checked", sent_words, checked);
    $display("tb: %0d steps fired, %0d commits rejected, %0d cycles", fires, rejects, cycles);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* edge_table_multi_pwm_core.f */
rtl/etmp_pkg.sv
rtl/etmp_dp.sv
rtl/etmp_ctrl.sv
rtl/edge_table_multi_pwm_core.sv
rtl/etmp_checker.sv
bench/tb.sv
